// File: hw/rtl/pwq_pkg.sv
`default_nettype none

package pwq_pkg;

   // Default geometry of the wait queue.
   localparam int QUEUE_DEPTH_DEF    = 32;
   localparam int WAITER_ID_BITS_DEF = 8;

   // Fixed payload widths.
   localparam int PRI_W  = 8;
   localparam int CHAN_W = 32;

   // Request codes.
   typedef enum logic [2:0] {
      REQ_INSERT        = 3'd0,
      REQ_WAKE_HEAD     = 3'd1,
      REQ_WAKE_ALL      = 3'd2,
      REQ_UNSLEEP       = 3'd3,
      REQ_DEQUEUE       = 3'd4,
      REQ_WAKE_ONE_CHAN = 3'd5,
      REQ_WAKE_ALL_CHAN = 3'd6
   } req_kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_INS_HEAD,
      ST_RM,
      ST_FINAL
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/priority_wait_queue_core.sv
`default_nettype none
// Rejected inserts and inserts into an empty queue are answered from idle; other inserts read from
// the tail toward the head, shifting lower-priority waiters down. A removal sweeps every held
// waiter and streams its removals out; an empty queue goes straight to the final result.
// Throughput: one request at a time; busy stays high while the slot memory is swept and drops
// as the final result is strobed. Reset: synchronous; clears the sequencer, fill count and valid
// flags. Results are single-cycle strobes on rsp_valid; the receiver cannot stall them.
module priority_wait_queue_core #(
   parameter int QUEUE_DEPTH    = pwq_pkg::QUEUE_DEPTH_DEF,
   parameter int WAITER_ID_BITS = pwq_pkg::WAITER_ID_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [2:0]                         req_type,
   input  wire logic [WAITER_ID_BITS-1:0]          req_waiter_id,
   input  wire logic [pwq_pkg::PRI_W-1:0]          req_priority_req,
   input  wire logic [pwq_pkg::CHAN_W-1:0]         req_wait_channel,
   input  wire logic                               req_object_wait,
   output logic                                    rsp_valid,
   output logic [WAITER_ID_BITS-1:0]               rsp_waiter_id_res,
   output logic                                    rsp_found,
   output logic                                    rsp_woken,
   output logic [1:0]                              rsp_status,
   output logic                                    rsp_last,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]        rsp_occupancy
);
   import pwq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int ID_W  = WAITER_ID_BITS;

   // Sequencer and queue bookkeeping.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   end_ff, end_in;
   logic [CNT_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic               matched_ff, matched_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic [CNT_W-1:0]   pend_occ_ff, pend_occ_in;

   // Captured request.
   req_kind_type       kind_ff, kind_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [PRI_W-1:0]   pri_ff, pri_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic               obj_ff, obj_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_woken_ff, rsp_woken_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]   rsp_occ_ff, rsp_occ_in;

   // Slot memory ports.
   logic [ID_W-1:0]    mem_waiter [QUEUE_DEPTH];
   logic [PRI_W-1:0]   mem_pri    [QUEUE_DEPTH];
   logic [CHAN_W-1:0]  mem_chan   [QUEUE_DEPTH];
   logic               mem_obj    [QUEUE_DEPTH];
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ID_W-1:0]    mem_wid;
   logic [PRI_W-1:0]   mem_wpri;
   logic [CHAN_W-1:0]  mem_wchan;
   logic               mem_wobj;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [ID_W-1:0]    rd_id_ff;
   logic [PRI_W-1:0]   rd_pri_ff;
   logic [CHAN_W-1:0]  rd_chan_ff;
   logic               rd_obj_ff;

   logic               chan_hit;
   logic               hit;
   logic               accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Slot memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_waiter[mem_waddr] <= mem_wid;
         mem_pri[mem_waddr]    <= mem_wpri;
         mem_chan[mem_waddr]   <= mem_wchan;
         mem_obj[mem_waddr]    <= mem_wobj;
      end
      if (rd_en) begin
         rd_idx_ff  <= rd_addr;
         rd_id_ff   <= mem_waiter[rd_addr];
         rd_pri_ff  <= mem_pri[rd_addr];
         rd_chan_ff <= mem_chan[rd_addr];
         rd_obj_ff  <= mem_obj[rd_addr];
      end
   end

   // Match test for the slot just read during a removal sweep.
   assign chan_hit = (rd_chan_ff == chan_ff) && !rd_obj_ff;

   always_comb begin
      unique case (kind_ff)
         REQ_WAKE_HEAD:     hit = !matched_ff;
         REQ_WAKE_ALL:      hit = 1'b1;
         REQ_UNSLEEP,
         REQ_DEQUEUE:       hit = !matched_ff && (rd_id_ff == id_ff);
         REQ_WAKE_ONE_CHAN: hit = !matched_ff && chan_hit;
         REQ_WAKE_ALL_CHAN: hit = chan_hit;
         default:           hit = 1'b0;
      endcase
   end

   // Sequencer: next state, memory accesses and results.
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      end_in        = end_ff;
      wr_ptr_in     = wr_ptr_ff;
      matched_in    = matched_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_occ_in   = pend_occ_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      pri_in        = pri_ff;
      chan_in       = chan_ff;
      obj_in        = obj_ff;
      rsp_valid_in  = 1'b0;
      rsp_id_in     = rsp_id_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_woken_in  = rsp_woken_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wid       = id_ff;
      mem_wpri      = pri_ff;
      mem_wchan     = chan_ff;
      mem_wobj      = obj_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_kind_type'(req_type);
               id_in         = req_waiter_id;
               pri_in        = req_priority_req;
               chan_in       = req_wait_channel;
               obj_in        = req_object_wait;
               matched_in    = 1'b0;
               pend_valid_in = 1'b0;
               pos_in        = '0;
               wr_ptr_in     = '0;
               end_in        = fill_ff;
               unique case (req_kind_type'(req_type))
                  REQ_INSERT: begin
                     if (fill_ff == CNT_W'(QUEUE_DEPTH)) begin
                        // Full: reject and leave the queue alone.
                        rsp_valid_in  = 1'b1;
                        rsp_id_in     = req_waiter_id;
                        rsp_found_in  = 1'b0;
                        rsp_woken_in  = 1'b0;
                        rsp_status_in = STATUS_FULL;
                        rsp_last_in   = 1'b1;
                        rsp_occ_in    = fill_ff;
                     end else if (fill_ff == '0) begin
                        // Empty: the new waiter becomes the head at once.
                        mem_we        = 1'b1;
                        mem_waddr     = '0;
                        mem_wid       = req_waiter_id;
                        mem_wpri      = req_priority_req;
                        mem_wchan     = req_wait_channel;
                        mem_wobj      = req_object_wait;
                        fill_in       = fill_ff + CNT_W'(1);
                        rsp_valid_in  = 1'b1;
                        rsp_id_in     = req_waiter_id;
                        rsp_found_in  = 1'b1;
                        rsp_woken_in  = 1'b0;
                        rsp_status_in = STATUS_OK;
                        rsp_last_in   = 1'b1;
                        rsp_occ_in    = fill_ff + CNT_W'(1);
                     end else begin
                        pos_in   = fill_ff;
                        state_in = ST_INS;
                     end
                  end
                  REQ_WAKE_HEAD, REQ_WAKE_ALL, REQ_UNSLEEP, REQ_DEQUEUE,
                  REQ_WAKE_ONE_CHAN, REQ_WAKE_ALL_CHAN: begin
                     state_in = (fill_ff == '0) ? ST_FINAL : ST_RM;
                  end
                  default: begin
                     // Unused request code: accepted and dropped.
                  end
               endcase
            end
         end

         ST_INS: begin
            // Read from the tail toward the head, one slot a cycle.
            if (pos_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(pos_ff - CNT_W'(1));
               pos_in  = pos_ff - CNT_W'(1);
            end
            if (rd_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_idx_ff + IDX_W'(1);
               if (pri_ff > rd_pri_ff) begin
                  // Shift this slot one place down and keep looking.
                  mem_wid   = rd_id_ff;
                  mem_wpri  = rd_pri_ff;
                  mem_wchan = rd_chan_ff;
                  mem_wobj  = rd_obj_ff;
                  if (rd_idx_ff == '0) begin
                     state_in = ST_INS_HEAD;
                  end
               end else begin
                  // New waiter goes right behind this slot.
                  fill_in       = fill_ff + CNT_W'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = id_ff;
                  rsp_found_in  = 1'b1;
                  rsp_woken_in  = 1'b0;
                  rsp_status_in = STATUS_OK;
                  rsp_last_in   = 1'b1;
                  rsp_occ_in    = fill_ff + CNT_W'(1);
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_INS_HEAD: begin
            mem_we        = 1'b1;
            mem_waddr     = '0;
            fill_in       = fill_ff + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_id_in     = id_ff;
            rsp_found_in  = 1'b1;
            rsp_woken_in  = 1'b0;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = 1'b1;
            rsp_occ_in    = fill_ff + CNT_W'(1);
            state_in      = ST_IDLE;
         end

         ST_RM: begin
            // Sweep from the head; kept slots are packed down at wr_ptr.
            if (pos_ff < end_ff) begin
               rd_en   = 1'b1;
               rd_addr = pos_ff[IDX_W-1:0];
               pos_in  = pos_ff + CNT_W'(1);
            end
            if (rd_valid_ff) begin
               if (hit) begin
                  // A removal is held back one match so its last flag is known.
                  fill_in    = fill_ff - CNT_W'(1);
                  matched_in = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_id_in     = pend_id_ff;
                     rsp_found_in  = 1'b1;
                     rsp_woken_in  = (kind_ff != REQ_DEQUEUE);
                     rsp_status_in = STATUS_OK;
                     rsp_last_in   = 1'b0;
                     rsp_occ_in    = pend_occ_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_id_ff;
                  pend_occ_in   = fill_ff - CNT_W'(1);
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ptr_ff[IDX_W-1:0];
                  mem_wid   = rd_id_ff;
                  mem_wpri  = rd_pri_ff;
                  mem_wchan = rd_chan_ff;
                  mem_wobj  = rd_obj_ff;
                  wr_ptr_in = wr_ptr_ff + CNT_W'(1);
               end
               if (CNT_W'(rd_idx_ff) + CNT_W'(1) == end_ff) begin
                  state_in = ST_FINAL;
               end
            end
         end

         ST_FINAL: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            if (pend_valid_ff) begin
               rsp_id_in     = pend_id_ff;
               rsp_found_in  = 1'b1;
               rsp_woken_in  = (kind_ff != REQ_DEQUEUE);
               rsp_status_in = STATUS_OK;
               rsp_occ_in    = pend_occ_ff;
            end else begin
               // Nothing removed: named removals echo the identifier.
               rsp_id_in     = (kind_ff == REQ_UNSLEEP || kind_ff == REQ_DEQUEUE) ?
                               id_ff : '0;
               rsp_found_in  = 1'b0;
               rsp_woken_in  = 1'b0;
               rsp_status_in = STATUS_EMPTY;
               rsp_occ_in    = fill_ff;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_valid_in = rd_en;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      end_ff        <= end_in;
      wr_ptr_ff     <= wr_ptr_in;
      matched_ff    <= matched_in;
      pend_id_ff    <= pend_id_in;
      pend_occ_ff   <= pend_occ_in;
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      pri_ff        <= pri_in;
      chan_ff       <= chan_in;
      obj_ff        <= obj_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_woken_ff  <= rsp_woken_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_waiter_id_res = rsp_id_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_woken         = rsp_woken_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_occupancy     = rsp_occ_ff;

   // The fill count never passes the queue depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count above queue depth");

   // A rejected insert is only reported when the queue is full.
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |-> rsp_occ_ff == CNT_W'(QUEUE_DEPTH))
      else $error("full status with free slots");

   // Compaction never writes ahead of the slot being read.
   a_compact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RM && mem_we) |-> wr_ptr_ff <= CNT_W'(rd_idx_ff))
      else $error("compaction write overtook the read sweep");

   // A result that removes or inserts nothing always closes its request.
   a_notfound_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_last_ff)
      else $error("not-found result without last");

   // No removal is left pending once the sequencer is back to idle.
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending removal lost");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import pwq_pkg::*;

   localparam int DEPTH        = QUEUE_DEPTH_DEF;
   localparam int ID_W         = WAITER_ID_BITS_DEF;
   localparam int OCC_W        = $clog2(DEPTH + 1);
   localparam int CYCLE_LIMIT  = 200000;
   // A removal sweeps every held waiter, so allow about two sweeps after the last result.
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   // One result as the block should report it.
   typedef struct {
      logic [ID_W-1:0]  waiter;
      logic             found;
      logic             woken;
      logic [1:0]       status;
      logic             last;
      logic [OCC_W-1:0] occ;
   } wake_result_type;

   // Scoreboard: mirrors the priority-ordered store and holds the results still due.
   class wait_queue_scoreboard;
      logic [ID_W-1:0]   held_id[DEPTH];
      logic [PRI_W-1:0]  held_pri[DEPTH];
      logic [CHAN_W-1:0] held_chan[DEPTH];
      logic              held_obj[DEPTH];
      int                held_count;
      wake_result_type   results_due[$];
      int                errors;

      function new();
         held_count = 0;
         errors = 0;
      endfunction

      function void push_result(logic [ID_W-1:0] w, logic f, logic wk, status_type st,
                                logic l);
         wake_result_type r;
         r.waiter = w;
         r.found = f;
         r.woken = wk;
         r.status = st;
         r.last = l;
         r.occ = OCC_W'(held_count);
         results_due.push_back(r);
      endfunction

      // Close the gap left by a removed waiter.
      function void drop_waiter(int pos);
         for (int i = pos; i + 1 < held_count; i++) begin
            held_id[i] = held_id[i + 1];
            held_pri[i] = held_pri[i + 1];
            held_chan[i] = held_chan[i + 1];
            held_obj[i] = held_obj[i + 1];
         end
         held_count--;
      endfunction

      // Note an accepted request and work out the results it causes.
      function void record_request(logic [2:0] kind, logic [ID_W-1:0] id,
                                   logic [PRI_W-1:0] pri, logic [CHAN_W-1:0] chan,
                                   logic obj);
         int              pos;
         int              n;
         bit              done;
         logic [ID_W-1:0] w;
         case (kind)
            REQ_INSERT: begin
               if (held_count >= DEPTH) begin
                  push_result(id, 1'b0, 1'b0, STATUS_FULL, 1'b1);
               end else begin
                  // Place the new waiter after every one of greater or equal priority.
                  pos = 0;
                  while (pos < held_count && pri <= held_pri[pos]) pos++;
                  for (int i = held_count; i > pos; i--) begin
                     held_id[i] = held_id[i - 1];
                     held_pri[i] = held_pri[i - 1];
                     held_chan[i] = held_chan[i - 1];
                     held_obj[i] = held_obj[i - 1];
                  end
                  held_id[pos] = id;
                  held_pri[pos] = pri;
                  held_chan[pos] = chan;
                  held_obj[pos] = obj;
                  held_count++;
                  push_result(id, 1'b1, 1'b0, STATUS_OK, 1'b1);
               end
            end
            REQ_WAKE_HEAD, REQ_WAKE_ALL: begin
               if (held_count == 0) begin
                  push_result('0, 1'b0, 1'b0, STATUS_EMPTY, 1'b1);
               end else begin
                  do begin
                     w = held_id[0];
                     drop_waiter(0);
                     push_result(w, 1'b1, 1'b1, STATUS_OK,
                                 kind == REQ_WAKE_HEAD || held_count == 0);
                  end while (kind == REQ_WAKE_ALL && held_count > 0);
               end
            end
            REQ_UNSLEEP, REQ_DEQUEUE: begin
               // A named removal takes the first match from the head.
               pos = 0;
               done = 1'b0;
               while (!done && pos < held_count) begin
                  if (held_id[pos] == id) begin
                     drop_waiter(pos);
                     push_result(id, 1'b1, kind == REQ_UNSLEEP, STATUS_OK, 1'b1);
                     done = 1'b1;
                  end else begin
                     pos++;
                  end
               end
               if (!done) push_result(id, 1'b0, 1'b0, STATUS_EMPTY, 1'b1);
            end
            REQ_WAKE_ONE_CHAN, REQ_WAKE_ALL_CHAN: begin
               // Object waits never match a channel wake.
               n = 0;
               pos = 0;
               done = 1'b0;
               while (!done && pos < held_count) begin
                  if (held_chan[pos] == chan && !held_obj[pos]) begin
                     w = held_id[pos];
                     drop_waiter(pos);
                     push_result(w, 1'b1, 1'b1, STATUS_OK, 1'b0);
                     n++;
                     if (kind == REQ_WAKE_ONE_CHAN) done = 1'b1;
                  end else begin
                     pos++;
                  end
               end
               if (n == 0) push_result('0, 1'b0, 1'b0, STATUS_EMPTY, 1'b1);
               else results_due[results_due.size() - 1].last = 1'b1;
            end
            default: begin
               // The unused code is ignored and causes no result.
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compare one result with the oldest one due.
      function void check_result(logic [ID_W-1:0] w, logic f, logic wk, logic [1:0] st,
                                 logic l, logic [OCC_W-1:0] occ);
         wake_result_type e;
         if (results_due.size() == 0) begin
            $display("%0t: result with none due, expected none, actual waiter %0h",
                     $time, w);
            errors++;
         end else begin
            e = results_due.pop_front();
            compare_field("waiter id", e.waiter, w);
            compare_field("found", e.found, f);
            compare_field("woken", e.woken, wk);
            compare_field("status", e.status, st);
            compare_field("last", e.last, l);
            compare_field("occupancy", e.occ, occ);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_type = '0;
   logic [ID_W-1:0]   req_waiter_id = '0;
   logic [PRI_W-1:0]  req_priority_req = '0;
   logic [CHAN_W-1:0] req_wait_channel = '0;
   logic              req_object_wait = 1'b0;
   logic              rsp_valid;
   logic [ID_W-1:0]   rsp_waiter_id_res;
   logic              rsp_found;
   logic              rsp_woken;
   logic [1:0]        rsp_status;
   logic              rsp_last;
   logic [OCC_W-1:0]  rsp_occupancy;

   wait_queue_scoreboard sb;
   int                   gap_percent = 26;
   int                   cycle_count = 0;
   logic [CHAN_W-1:0]    chan_pool[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
                                          32'hA5A5_0001};

   priority_wait_queue_core #(
      .QUEUE_DEPTH   (DEPTH),
      .WAITER_ID_BITS(ID_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_waiter_id    (req_waiter_id),
      .req_priority_req (req_priority_req),
      .req_wait_channel (req_wait_channel),
      .req_object_wait  (req_object_wait),
      .rsp_valid        (rsp_valid),
      .rsp_waiter_id_res(rsp_waiter_id_res),
      .rsp_found        (rsp_found),
      .rsp_woken        (rsp_woken),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .rsp_occupancy    (rsp_occupancy)
   );

   // Free-running clock, 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Every strobed result is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_waiter_id_res, rsp_found, rsp_woken, rsp_status, rsp_last,
                         rsp_occupancy);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Present one request after a random gap and hold it until the transfer.
   task automatic send_item(input logic [2:0] kind, input logic [ID_W-1:0] id,
                            input logic [PRI_W-1:0] pri, input logic [CHAN_W-1:0] chan,
                            input logic obj);
      while ($urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_waiter_id <= id;
      req_priority_req <= pri;
      req_wait_channel <= chan;
      req_object_wait <= obj;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.record_request(kind, id, pri, chan, obj);
   endtask

   // Mostly well-formed requests: ids, priorities and channels from small pools or from
   // waiters actually held, so that named and channel removals find something.
   task automatic random_item(input int insert_percent);
      int                r;
      int                k;
      logic [2:0]        kind;
      logic [ID_W-1:0]   id;
      logic [PRI_W-1:0]  pri;
      logic [CHAN_W-1:0] chan;
      logic              obj;
      r = $urandom_range(99);
      if (r < insert_percent) kind = REQ_INSERT;
      else if (r < 97) kind = 3'($urandom_range(REQ_WAKE_ALL_CHAN, REQ_WAKE_HEAD));
      else kind = REQ_UNUSED;
      k = (sb.held_count > 0) ? $urandom_range(sb.held_count - 1) : 0;

      if (sb.held_count > 0 && (kind == REQ_UNSLEEP || kind == REQ_DEQUEUE) &&
          $urandom_range(3) != 0) id = sb.held_id[k];
      else if ($urandom_range(3) == 0) id = ID_W'($urandom);
      else id = ID_W'($urandom_range(15));

      if ($urandom_range(1) == 0) pri = PRI_W'($urandom);
      else pri = PRI_W'($urandom_range(3) * 85);

      if (sb.held_count > 0 && (kind == REQ_WAKE_ONE_CHAN || kind == REQ_WAKE_ALL_CHAN) &&
          $urandom_range(2) != 0) chan = sb.held_chan[k];
      else if ($urandom_range(3) == 0) chan = $urandom;
      else chan = chan_pool[$urandom_range(3)];

      obj = ($urandom_range(3) == 0);
      send_item(kind, id, pri, chan, obj);
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Removals on an empty queue.
      send_item(REQ_WAKE_HEAD, 8'h00, 8'h00, 32'h0, 1'b0);
      send_item(REQ_WAKE_ALL, 8'h00, 8'h00, 32'h0, 1'b0);
      send_item(REQ_UNSLEEP, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      send_item(REQ_DEQUEUE, 8'h00, 8'h00, 32'h0, 1'b0);
      send_item(REQ_WAKE_ONE_CHAN, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0);
      send_item(REQ_WAKE_ALL_CHAN, 8'h00, 8'h00, 32'h0, 1'b0);

      // Inserts at the field extremes, with a tie in priority at both ends.
      send_item(REQ_INSERT, 8'h00, 8'h00, 32'h0000_0000, 1'b0);
      send_item(REQ_INSERT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      send_item(REQ_INSERT, 8'h55, 8'hFF, 32'h0000_0000, 1'b0);
      send_item(REQ_INSERT, 8'hAA, 8'h00, 32'hFFFF_FFFF, 1'b0);
      send_item(REQ_INSERT, 8'h3C, 8'h80, 32'h0000_0000, 1'b1);

      // The unused code with every bit set; nothing should come back.
      send_item(REQ_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);

      // Channel wakes skip object waits; then a channel that nobody waits on.
      send_item(REQ_WAKE_ONE_CHAN, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0);
      send_item(REQ_WAKE_ALL_CHAN, 8'h00, 8'h00, 32'h0000_0000, 1'b0);
      send_item(REQ_WAKE_ALL_CHAN, 8'h00, 8'h00, 32'h1234_5678, 1'b0);

      // Named removals, without and with wakeup, emptying the queue.
      send_item(REQ_DEQUEUE, 8'h3C, 8'h00, 32'h0, 1'b0);
      send_item(REQ_UNSLEEP, 8'hFF, 8'h00, 32'h0, 1'b0);

      // A duplicate id: the named removal takes the one nearer the head.
      send_item(REQ_INSERT, 8'h11, 8'h10, 32'h0000_0007, 1'b0);
      send_item(REQ_INSERT, 8'h22, 8'h10, 32'h0000_0007, 1'b0);
      send_item(REQ_INSERT, 8'h11, 8'h10, 32'h0000_0007, 1'b0);
      send_item(REQ_UNSLEEP, 8'h11, 8'h00, 32'h0, 1'b0);
      send_item(REQ_WAKE_HEAD, 8'h00, 8'h00, 32'h0, 1'b0);
      send_item(REQ_INSERT, 8'h01, 8'hC8, 32'h0000_0007, 1'b1);
      send_item(REQ_INSERT, 8'h02, 8'h01, 32'h0000_0009, 1'b0);
      send_item(REQ_WAKE_ALL, 8'h00, 8'h00, 32'h0, 1'b0);

      // Insert-heavy phase that runs the queue into the full case.
      repeat (45) random_item(95);
      // A stretch with no gaps at all.
      gap_percent = 0;
      repeat (25) random_item(50);
      gap_percent = 26;
      repeat (25) random_item(40);
      start <= 1'b0;

      while (sb.results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: priority_wait_queue_core.f
hw/rtl/pwq_pkg.sv
hw/rtl/priority_wait_queue_core.sv
dv/testbench.sv
